// ===== rtl/polar_pose_controller_core_assert.svh =====
// Assertion macros used by the controller's queue.
`ifndef POLAR_POSE_CONTROLLER_CORE_ASSERT_SVH
`define POLAR_POSE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication.
`define PPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppc assertion failed");

// Next-cycle implication.
`define PPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppc assertion failed");

`endif

// ===== rtl/ppc_pkg.sv =====
package ppc_pkg;

   localparam int POS_W      = 24;
   localparam int ANG_W      = 16;
   localparam int GAIN_W     = 16;
   localparam int THR_W      = 23;
   localparam int OUT_W      = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   localparam int DIFF_W = POS_W + 1;     // goal - robot
   localparam int CX_W   = 44;            // cordic x/y, diff scaled by 2^16 plus growth
   localparam int CZ_W   = 24;            // cordic angle, 2^-20 rad
   localparam int ROOT_W = 25;            // rho
   localparam int SQ_W   = 2 * DIFF_W;    // one square
   localparam int REM_W  = SQ_W + 1;      // sum of squares / remainder
   localparam int WRAP_W = 18;            // angle arithmetic before wrap

   localparam int CORDIC_STEPS    = 20;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DISTANCE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_BEARING       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_FINAL_ANGLE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_THRESHOLD = 3'd3;

   localparam logic signed [WRAP_W-1:0] PI_Q13          = 18'sd25736;
   localparam logic signed [WRAP_W-1:0] TWO_PI_Q13      = 18'sd51472;
   localparam logic signed [WRAP_W-1:0] HEADING_TOL_Q13 = 18'sd819;
   localparam logic signed [CZ_W-1:0]   HALF_PI_Q20     = 24'sd1647099;

   localparam logic signed [CZ_W-1:0] ATAN_Q20 [CORDIC_STEPS] = '{
      24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451,
      24'sd32757,  24'sd16383,  24'sd8192,   24'sd4096,   24'sd2048,
      24'sd1024,   24'sd512,    24'sd256,    24'sd128,    24'sd64,
      24'sd32,     24'sd16,     24'sd8,      24'sd4,      24'sd2
   };

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_distance;
      logic signed [GAIN_W-1:0] gain_bearing;
      logic signed [GAIN_W-1:0] gain_final_angle;
      logic [THR_W-1:0]         distance_threshold;
   } ppc_cfg_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [CX_W-1:0]   cx;
      logic signed [CX_W-1:0]   cy;
      logic signed [CZ_W-1:0]   cz;
      logic                     on_goal;
      logic signed [ANG_W-1:0]  rh;
      logic                     heading_ok;
   } ppc_item_type;

   // wrap into (-pi, pi]; one step suffices for all inputs used here
   function automatic logic signed [WRAP_W-1:0] wrap_angle(
      input logic signed [WRAP_W-1:0] a);
      logic signed [WRAP_W-1:0] r;
      r = a;
      if (a > PI_Q13) begin
         r = a - TWO_PI_Q13;
      end else if (a <= -PI_Q13) begin
         r = a + TWO_PI_Q13;
      end
      return r;
   endfunction

endpackage

// ===== rtl/polar_pose_controller_core.sv =====
// Polar pose controller. Each transaction carries robot pose and goal pose
// (Q11.12 positions, Q2.13 headings); one result transaction comes back per
// input: linear velocity = gain_distance*rho, angular velocity =
// gain_bearing*alpha + gain_final_angle*beta (both Q11.12, saturated), and a
// goal-reached flag. A transaction is taken when start is high and busy is
// low; a new one may follow every cycle while busy stays low. Each result
// appears on the rsp_ ports for exactly one cycle with rsp_strobe high and
// cannot be held off, so the receiver must take it then. Results keep input
// order. A transaction passes one front stage, the queue's memory and output
// registers, 27 rotation/square-root stages (square, sum, then one root bit
// per stage), and registers for angle wrap, multiply and round/saturate. The
// user must write gains and threshold through the csr_ port only while no
// transaction is in flight; the block itself does not enforce this.
module polar_pose_controller_core #(
   parameter int QUEUE_DEPTH = ppc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request transaction
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [ppc_pkg::POS_W-1:0]      req_robot_x,
   input  logic signed [ppc_pkg::POS_W-1:0]      req_robot_y,
   input  logic signed [ppc_pkg::ANG_W-1:0]      req_robot_heading,
   input  logic signed [ppc_pkg::POS_W-1:0]      req_goal_x,
   input  logic signed [ppc_pkg::POS_W-1:0]      req_goal_y,
   input  logic signed [ppc_pkg::ANG_W-1:0]      req_goal_heading,
   // result transaction
   output logic                                  rsp_strobe,
   output logic signed [ppc_pkg::OUT_W-1:0]      rsp_linear_velocity,
   output logic signed [ppc_pkg::OUT_W-1:0]      rsp_angular_velocity,
   output logic                                  rsp_goal_reached,
   // register writes
   input  logic                                  csr_write_enable,
   input  logic [ppc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ppc_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   import ppc_pkg::*;

   ppc_cfg_type  cfg_ff;
   logic         q_full;
   logic         push;
   ppc_item_type push_item;
   logic         q_valid;
   ppc_item_type q_item;

   // Control registers; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GAIN_DISTANCE: begin
               cfg_ff.gain_distance <= $signed(csr_write_data[GAIN_W-1:0]);
            end
            CSR_GAIN_BEARING: begin
               cfg_ff.gain_bearing <= $signed(csr_write_data[GAIN_W-1:0]);
            end
            CSR_GAIN_FINAL_ANGLE: begin
               cfg_ff.gain_final_angle <= $signed(csr_write_data[GAIN_W-1:0]);
            end
            CSR_DISTANCE_THRESHOLD: begin
               cfg_ff.distance_threshold <= csr_write_data[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Front: accept, form differences, pre-rotate, heading check.
   ppc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .robot_x       (req_robot_x),
      .robot_y       (req_robot_y),
      .robot_heading (req_robot_heading),
      .goal_x        (req_goal_x),
      .goal_y        (req_goal_y),
      .goal_heading  (req_goal_heading),
      .q_full        (q_full),
      .push          (push),
      .push_item     (push_item)
   );

   // Short decoupling queue between the two halves.
   ppc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .out_valid (q_valid),
      .out_item  (q_item)
   );

   // Back: CORDIC bearing, digit-by-digit sqrt, gains, saturation.
   ppc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .in_valid             (q_valid),
      .in_item              (q_item),
      .rsp_strobe           (rsp_strobe),
      .rsp_linear_velocity  (rsp_linear_velocity),
      .rsp_angular_velocity (rsp_angular_velocity),
      .rsp_goal_reached     (rsp_goal_reached)
   );

endmodule

// ===== rtl/ppc_front.sv =====
module ppc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [ppc_pkg::POS_W-1:0]  robot_x,
   input  logic signed [ppc_pkg::POS_W-1:0]  robot_y,
   input  logic signed [ppc_pkg::ANG_W-1:0]  robot_heading,
   input  logic signed [ppc_pkg::POS_W-1:0]  goal_x,
   input  logic signed [ppc_pkg::POS_W-1:0]  goal_y,
   input  logic signed [ppc_pkg::ANG_W-1:0]  goal_heading,
   input  logic                              q_full,
   output logic                              push,
   output ppc_pkg::ppc_item_type             push_item
);
   import ppc_pkg::*;

   logic                     f_valid_ff;
   ppc_item_type             f_item_ff;
   ppc_item_type             item_in;
   logic                     accept;
   logic                     advance;
   logic signed [DIFF_W-1:0] dx;
   logic signed [DIFF_W-1:0] dy;
   logic signed [CX_W-1:0]   x0;
   logic signed [CX_W-1:0]   y0;
   logic signed [WRAP_W-1:0] hd;

   assign busy    = f_valid_ff && q_full;
   assign accept  = start && !busy;
   assign advance = !f_valid_ff || !q_full;
   assign push    = f_valid_ff && !q_full;
   assign push_item = f_item_ff;

   assign dx = DIFF_W'(goal_x) - DIFF_W'(robot_x);
   assign dy = DIFF_W'(goal_y) - DIFF_W'(robot_y);
   assign x0 = CX_W'(dx) <<< 16;
   assign y0 = CX_W'(dy) <<< 16;
   assign hd = wrap_angle(WRAP_W'(goal_heading) - WRAP_W'(robot_heading));

   always_comb begin
      item_in.dx         = dx;
      item_in.dy         = dy;
      item_in.on_goal    = (dx == '0) && (dy == '0);
      item_in.rh         = robot_heading;
      item_in.heading_ok = (hd > -HEADING_TOL_Q13) && (hd < HEADING_TOL_Q13);
      // left half plane: quarter-turn into the right half first
      if (dx < 0) begin
         if (dy >= 0) begin
            item_in.cx = y0;
            item_in.cy = -x0;
            item_in.cz = HALF_PI_Q20;
         end else begin
            item_in.cx = -y0;
            item_in.cy = x0;
            item_in.cz = -HALF_PI_Q20;
         end
      end else begin
         item_in.cx = x0;
         item_in.cy = y0;
         item_in.cz = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (advance) begin
         f_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && accept) begin
         f_item_ff <= item_in;
      end
   end

endmodule

// ===== rtl/ppc_queue.sv =====
module ppc_queue #(
   parameter int DEPTH = ppc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ppc_pkg::ppc_item_type push_item,
   output logic                  full,
   output logic                  out_valid,
   output ppc_pkg::ppc_item_type out_item
);
   import ppc_pkg::*;

   `include "polar_pose_controller_core_assert.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ppc_item_type     mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             out_valid_ff;
   ppc_item_type     out_item_ff;
   logic             pop;

   // back end never stalls, so drain every cycle
   assign pop       = count_ff != '0;
   assign full      = count_ff == CNT_W'(DEPTH);
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= pop;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
      if (pop) begin
         out_item_ff <= mem[rd_ptr_ff];
      end
   end

   `PPC_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !full)
   `PPC_ASSERT_IMPLY(a_drained, clock, reset, 1'b1, count_ff <= CNT_W'(1))
   `PPC_ASSERT_NEXT(a_push_held, clock, reset, push, count_ff != '0)

endmodule

// ===== rtl/ppc_back.sv =====
module ppc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  ppc_pkg::ppc_cfg_type              cfg,
   input  logic                              in_valid,
   input  ppc_pkg::ppc_item_type             in_item,
   output logic                              rsp_strobe,
   output logic signed [ppc_pkg::OUT_W-1:0]  rsp_linear_velocity,
   output logic signed [ppc_pkg::OUT_W-1:0]  rsp_angular_velocity,
   output logic                              rsp_goal_reached
);
   import ppc_pkg::*;

   localparam int NST  = 2 + ROOT_W;          // square, sum, one stage per root bit
   localparam int LAST = NST - 1;
   localparam int PV_W = GAIN_W + ROOT_W + 1;
   localparam int PA_W = GAIN_W + WRAP_W;
   localparam logic signed [PV_W-1:0] SAT_HI = PV_W'(2 ** (OUT_W - 1) - 1);
   localparam logic signed [PV_W-1:0] SAT_LO = -SAT_HI - PV_W'(1);

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PV_W-1:0] v);
      logic signed [OUT_W-1:0] r;
      r = v[OUT_W-1:0];
      if (v > SAT_HI) begin
         r = SAT_HI[OUT_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[OUT_W-1:0];
      end
      return r;
   endfunction

   // rotation + square root pipeline
   logic                    valid_ff [NST];
   logic signed [CX_W-1:0]  cx_ff    [NST];
   logic signed [CX_W-1:0]  cy_ff    [NST];
   logic signed [CZ_W-1:0]  cz_ff    [NST];
   logic                    og_ff    [NST];
   logic signed [ANG_W-1:0] rh_ff    [NST];
   logic                    hok_ff   [NST];
   logic [REM_W-1:0]        rem_ff   [NST];
   logic [ROOT_W-1:0]       root_ff  [NST];
   logic [REM_W-1:0]        sqy_ff;

   for (genvar k = 0; k < NST; k++) begin : g_stage
      logic                    v_src;
      logic signed [CX_W-1:0]  x_src;
      logic signed [CX_W-1:0]  y_src;
      logic signed [CZ_W-1:0]  z_src;
      logic                    og_src;
      logic signed [ANG_W-1:0] rh_src;
      logic                    hok_src;
      logic signed [CX_W-1:0]  x_in;
      logic signed [CX_W-1:0]  y_in;
      logic signed [CZ_W-1:0]  z_in;
      logic [REM_W-1:0]        rem_in;
      logic [ROOT_W-1:0]       root_in;

      if (k == 0) begin : g_src_in
         assign v_src   = in_valid;
         assign x_src   = in_item.cx;
         assign y_src   = in_item.cy;
         assign z_src   = in_item.cz;
         assign og_src  = in_item.on_goal;
         assign rh_src  = in_item.rh;
         assign hok_src = in_item.heading_ok;
      end else begin : g_src_prev
         assign v_src   = valid_ff[k-1];
         assign x_src   = cx_ff[k-1];
         assign y_src   = cy_ff[k-1];
         assign z_src   = cz_ff[k-1];
         assign og_src  = og_ff[k-1];
         assign rh_src  = rh_ff[k-1];
         assign hok_src = hok_ff[k-1];
      end

      if (k < CORDIC_STEPS) begin : g_rot
         always_comb begin
            if (y_src > 0) begin
               x_in = x_src + (y_src >>> k);
               y_in = y_src - (x_src >>> k);
               z_in = z_src + ATAN_Q20[k];
            end else begin
               x_in = x_src - (y_src >>> k);
               y_in = y_src + (x_src >>> k);
               z_in = z_src - ATAN_Q20[k];
            end
         end
      end else begin : g_hold
         assign x_in = x_src;
         assign y_in = y_src;
         assign z_in = z_src;
      end

      if (k == 0) begin : g_square
         assign rem_in  = REM_W'($unsigned(SQ_W'(in_item.dx * in_item.dx)));
         assign root_in = '0;
         always_ff @(posedge clock) begin
            sqy_ff <= REM_W'($unsigned(SQ_W'(in_item.dy * in_item.dy)));
         end
      end else if (k == 1) begin : g_sum
         assign rem_in  = rem_ff[0] + sqy_ff;
         assign root_in = '0;
      end else begin : g_root
         localparam int B = LAST - k;
         logic [REM_W-1:0] trial;
         assign trial = (REM_W'(root_ff[k-1]) << (B + 1)) | (REM_W'(1) << (2 * B));
         always_comb begin
            if (rem_ff[k-1] >= trial) begin
               rem_in  = rem_ff[k-1] - trial;
               root_in = root_ff[k-1] | (ROOT_W'(1) << B);
            end else begin
               rem_in  = rem_ff[k-1];
               root_in = root_ff[k-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         cx_ff[k]   <= x_in;
         cy_ff[k]   <= y_in;
         cz_ff[k]   <= z_in;
         og_ff[k]   <= og_src;
         rh_ff[k]   <= rh_src;
         hok_ff[k]  <= hok_src;
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
      end
   end

   // angles and arrival
   logic signed [CZ_W-1:0]   z_round;
   logic signed [WRAP_W-1:0] bearing;
   logic signed [WRAP_W-1:0] alpha_in;
   logic signed [WRAP_W-1:0] beta_in;
   logic                     reached_in;
   logic                     e1_valid_ff;
   logic [ROOT_W-1:0]        e1_rho_ff;
   logic signed [WRAP_W-1:0] e1_alpha_ff;
   logic signed [WRAP_W-1:0] e1_beta_ff;
   logic                     e1_reached_ff;

   assign z_round    = (cz_ff[LAST] + CZ_W'(64)) >>> 7;
   assign bearing    = og_ff[LAST] ? '0 : WRAP_W'(z_round);
   assign alpha_in   = wrap_angle(bearing - WRAP_W'(rh_ff[LAST]));
   assign beta_in    = wrap_angle(-alpha_in - WRAP_W'(rh_ff[LAST]));
   assign reached_in = (root_ff[LAST] < ROOT_W'(cfg.distance_threshold)) && hok_ff[LAST];

   // products
   logic                     e2_valid_ff;
   logic signed [PV_W-1:0]   e2_pv_ff;
   logic signed [PA_W-1:0]   e2_pa_ff;
   logic signed [PA_W-1:0]   e2_pb_ff;
   logic                     e2_reached_ff;

   // round and saturate
   logic signed [PV_W-1:0]   v_sum;
   logic signed [PV_W-1:0]   w_sum;
   logic                     out_strobe_ff;
   logic signed [OUT_W-1:0]  out_v_ff;
   logic signed [OUT_W-1:0]  out_w_ff;
   logic                     out_reached_ff;

   assign v_sum = (e2_pv_ff + PV_W'(128)) >>> 8;
   assign w_sum = (PV_W'(e2_pa_ff) + PV_W'(e2_pb_ff) + PV_W'(256)) >>> 9;

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff   <= 1'b0;
         e2_valid_ff   <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         e1_valid_ff   <= valid_ff[LAST];
         e2_valid_ff   <= e1_valid_ff;
         out_strobe_ff <= e2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      e1_rho_ff      <= root_ff[LAST];
      e1_alpha_ff    <= alpha_in;
      e1_beta_ff     <= beta_in;
      e1_reached_ff  <= reached_in;
      e2_pv_ff       <= PV_W'(cfg.gain_distance) * $signed({1'b0, e1_rho_ff});
      e2_pa_ff       <= PA_W'(cfg.gain_bearing) * PA_W'(e1_alpha_ff);
      e2_pb_ff       <= PA_W'(cfg.gain_final_angle) * PA_W'(e1_beta_ff);
      e2_reached_ff  <= e1_reached_ff;
      out_v_ff       <= sat_out(v_sum);
      out_w_ff       <= sat_out(w_sum);
      out_reached_ff <= e2_reached_ff;
   end

   assign rsp_strobe           = out_strobe_ff;
   assign rsp_linear_velocity  = out_v_ff;
   assign rsp_angular_velocity = out_w_ff;
   assign rsp_goal_reached     = out_reached_ff;

endmodule
